// ----- rtl/core/lmcs_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lmcs_pkg - shared types and constants of the LED matrix crossfade scanner
// Item kinds, configuration register indexes, PWM compare limits and the
// store command bundle passed from the top level to the frame stores.
// ============================================================================
package lmcs_pkg;

    localparam int DEF_COLUMNS = 12;
    localparam int DEF_ROWS    = 10;

    localparam int KIND_W   = 2;
    localparam int ELEM_W   = 8;
    localparam int WORD_W   = 16;
    localparam int SHIFT_W  = 4;
    localparam int BLEND_W  = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;
    localparam int SHIFTED_W = WORD_W + (2 ** SHIFT_W) - 1;

    // PWM compare window and the blend extremes.
    localparam logic [BLEND_W-1:0] CMP_MIN     = 8'h02;
    localparam logic [BLEND_W-1:0] CMP_MAX     = 8'hFD;
    localparam logic [BLEND_W-1:0] BLEND_LOW   = 8'h01;
    localparam logic [BLEND_W-1:0] BLEND_FULL  = 8'hFF;
    localparam logic [BLEND_W-1:0] BLEND_NONE  = 8'h00;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK      = 2'd0,
        KIND_WRITE     = 2'd1,
        KIND_CLEAR_COL = 2'd2,
        KIND_CLEAR_ALL = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLEND  = 1'b0,
        REG_TARGET = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic write;      // store a word at the position
        logic clear_col;  // clear the column at the position
        logic clear_all;  // clear every column
        logic target;     // 0 frame A, 1 frame B
    } t_store_cmd;

endpackage

// ----- rtl/core/lmcs_frame_store.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lmcs_frame_store - the two frame stores A and B
// One column word per entry. Writes and clears go to the store picked by the
// command; both stores are read at the current scan column.
// ============================================================================
module lmcs_frame_store
    import lmcs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    localparam int COL_W  = $clog2(COLUMNS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_store_cmd        i_cmd,
    input  logic [ELEM_W-1:0] i_pos,
    input  logic [ROWS-1:0]   i_word,
    input  logic [COL_W-1:0]  i_rd_col,
    output logic [ROWS-1:0]   o_col_a,
    output logic [ROWS-1:0]   o_col_b
);

    logic [ROWS-1:0] r_frame_a [COLUMNS];
    logic [ROWS-1:0] r_frame_b [COLUMNS];
    logic            w_pos_ok;
    logic [COL_W-1:0] w_idx;

    assign w_pos_ok = (i_pos < ELEM_W'(COLUMNS));
    assign w_idx    = i_pos[COL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < COLUMNS; c++) begin
                r_frame_a[c] <= '0;
                r_frame_b[c] <= '0;
            end
        end else if (i_cmd.clear_all) begin
            for (int c = 0; c < COLUMNS; c++) begin
                if (i_cmd.target) begin
                    r_frame_b[c] <= '0;
                end else begin
                    r_frame_a[c] <= '0;
                end
            end
        end else if ((i_cmd.write || i_cmd.clear_col) && w_pos_ok) begin
            if (i_cmd.target) begin
                r_frame_b[w_idx] <= i_cmd.write ? i_word : '0;
            end else begin
                r_frame_a[w_idx] <= i_cmd.write ? i_word : '0;
            end
        end
    end

    assign o_col_a = r_frame_a[i_rd_col];
    assign o_col_b = r_frame_b[i_rd_col];

endmodule

// ----- rtl/core/lmcs_pwm_scan.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lmcs_pwm_scan - PWM counter and column scan sequencer
// Each tick advances the 8-bit counter. At wrap frame A is shown (blank
// at blend none) and the shift clock rises; at the compare value frame B
// is shown (blank at blend full), the clock falls and the scan steps a column.
// ============================================================================
module lmcs_pwm_scan
    import lmcs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    localparam int COL_W  = $clog2(COLUMNS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic [BLEND_W-1:0] i_blend,
    input  logic [ROWS-1:0]    i_col_a,
    input  logic [ROWS-1:0]    i_col_b,
    output logic [COL_W-1:0]   o_scan_col,
    output logic [ROWS-1:0]    o_drive,
    output logic               o_data,
    output logic               o_clk_lvl
);

    logic [BLEND_W-1:0] r_count, n_count;
    logic [COL_W-1:0]   r_col,   n_col;
    logic [ROWS-1:0]    r_drive, n_drive;
    logic               r_data,  n_data;
    logic               r_clk,   n_clk;
    logic [BLEND_W-1:0] w_cmp;
    logic [BLEND_W-1:0] w_next;

    always_comb begin
        if (i_blend <= BLEND_LOW) begin
            w_cmp = CMP_MIN;
        end else if (i_blend > CMP_MAX) begin
            w_cmp = CMP_MAX;
        end else begin
            w_cmp = i_blend;
        end
    end

    assign w_next = r_count + BLEND_W'(1);

    always_comb begin
        n_count = r_count;
        n_col   = r_col;
        n_drive = r_drive;
        n_data  = r_data;
        n_clk   = r_clk;
        if (i_tick) begin
            n_count = w_next;
            if (w_next == '0) begin
                n_drive = (i_blend != BLEND_NONE) ? i_col_a : '0;
                n_clk   = 1'b1;
            end else if (w_next == w_cmp) begin
                n_drive = (i_blend != BLEND_FULL) ? i_col_b : '0;
                n_clk   = 1'b0;
                if (r_col >= COL_W'(COLUMNS - 1)) begin
                    // Last column: the data bit drops so a new scan starts.
                    n_data = 1'b0;
                    n_col  = '0;
                end else begin
                    if (r_col == '0) begin
                        n_data = 1'b1;
                    end
                    n_col = r_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_col   <= '0;
            r_drive <= '0;
            r_data  <= 1'b0;
            r_clk   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_col   <= n_col;
            r_drive <= n_drive;
            r_data  <= n_data;
            r_clk   <= n_clk;
        end
    end

    assign o_scan_col = r_col;
    assign o_drive    = r_drive;
    assign o_data     = r_data;
    assign o_clk_lvl  = r_clk;

endmodule

// ----- rtl/core/led_matrix_crossfade_scanner.sv -----
`timescale 1ns / 1ps
// ============================================================================
// led_matrix_crossfade_scanner - dual buffer LED matrix scanner with crossfade
// Scans a COLUMNS x ROWS matrix from two frame stores and blends them inside
// each column slot with an 8-bit PWM counter.
//
// Channel  Direction  Handshake                 Beat
// command  in         start, busy (always low)  kind, element, offset, word...
// result   out        o_result_valid strobe     row drive, column data, clock
// config   in         i_cfg_we                  register index, data
//
// One item is taken every clock; its result shows in the next cycle for exactly
// one cycle. All state updates land in the single register stage at the
// accepting edge, so the rate is one item per cycle. Synchronous active-low
// reset clears both stores, the counter and the scan. The result side cannot
// stall; busy stays low.
// ============================================================================
module led_matrix_crossfade_scanner
    import lmcs_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [ELEM_W-1:0]    i_element_index,
    input  logic signed [ELEM_W-1:0] i_x_offset,
    input  logic [WORD_W-1:0]    i_pixel_word,
    input  logic [SHIFT_W-1:0]   i_shift_amount,
    input  logic                 i_last_element,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic                 o_result_valid,
    output logic [ROWS-1:0]      o_row_drive,
    output logic                 o_column_data,
    output logic                 o_shift_clock
);

    localparam int COL_W = $clog2(COLUMNS);

    logic [BLEND_W-1:0]   r_blend;
    logic                 r_target;
    logic                 r_valid;
    logic                 w_accept;
    t_kind                w_kind;
    t_store_cmd           w_cmd;
    logic [ELEM_W-1:0]    w_pos;
    logic [SHIFTED_W-1:0] w_shifted;
    logic [ROWS-1:0]      w_col_a;
    logic [ROWS-1:0]      w_col_b;
    logic [COL_W-1:0]     w_scan_col;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_kind   = t_kind'(i_kind);

    // The end-of-image marker does not change the stores.
    always_comb begin
        w_cmd        = '0;
        w_cmd.target = r_target;
        w_pos        = i_element_index;
        case (w_kind)
            KIND_WRITE: begin
                w_cmd.write = w_accept;
                w_pos       = i_element_index + $unsigned(i_x_offset);
            end
            KIND_CLEAR_COL: w_cmd.clear_col = w_accept;
            KIND_CLEAR_ALL: w_cmd.clear_all = w_accept;
            default: ;
        endcase
    end

    assign w_shifted = SHIFTED_W'(i_pixel_word) << i_shift_amount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend  <= BLEND_FULL;
            r_target <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_BLEND:  r_blend  <= i_cfg_data[BLEND_W-1:0];
                    REG_TARGET: r_target <= i_cfg_data[0];
                endcase
            end
        end
    end

    lmcs_frame_store #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_pos    (w_pos),
        .i_word   (w_shifted[ROWS-1:0]),
        .i_rd_col (w_scan_col),
        .o_col_a  (w_col_a),
        .o_col_b  (w_col_b)
    );

    lmcs_pwm_scan #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (w_accept && (w_kind == KIND_TICK)),
        .i_blend    (r_blend),
        .i_col_a    (w_col_a),
        .i_col_b    (w_col_b),
        .o_scan_col (w_scan_col),
        .o_drive    (o_row_drive),
        .o_data     (o_column_data),
        .o_clk_lvl  (o_shift_clock)
    );

    assign o_result_valid = r_valid;

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_result_valid)
        else $error("result strobe missing after an accepted beat");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_col < COL_W'(COLUMNS - 1) || w_scan_col == COL_W'(COLUMNS - 1))
        else $error("scan column beyond the last column");

    a_store_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_kind != KIND_TICK) |=>
            ($stable(o_row_drive) && $stable(o_column_data) && $stable(o_shift_clock)))
        else $error("store item changed the matrix outputs");

    a_clock_rise_shows_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_shift_clock) |-> $past(w_accept && w_kind == KIND_TICK))
        else $error("shift clock rose without a tick");

endmodule

// ----- dv/led_matrix_crossfade_scanner_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// led_matrix_crossfade_scanner_tb - self-checking bench of the crossfade scanner
// Drives tick, write and clear beats through the start/busy command port and
// keeps its own copy of both frame stores, the PWM counter and the column scan.
// Every result strobe is checked against the oldest predicted output levels.
// ============================================================================
module led_matrix_crossfade_scanner_tb;
    import lmcs_pkg::*;

    localparam int COLUMNS       = DEF_COLUMNS;
    localparam int ROWS          = DEF_ROWS;
    localparam int SETTLE_CYCLES = 4;
    localparam int SLOT_TICKS    = 192;
    localparam int RANDOM_BEATS  = 120;
    localparam int RECONFIG_EVERY = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [ROWS-1:0] rows;
        logic            data;
        logic            shift_clk;
    } t_levels;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [KIND_W-1:0]    i_kind = KIND_TICK;
    logic [ELEM_W-1:0]    i_element_index = '0;
    logic signed [ELEM_W-1:0] i_x_offset = '0;
    logic [WORD_W-1:0]    i_pixel_word = '0;
    logic [SHIFT_W-1:0]   i_shift_amount = '0;
    logic                 i_last_element = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 o_result_valid;
    logic [ROWS-1:0]      o_row_drive;
    logic                 o_column_data;
    logic                 o_shift_clock;

    // Predicted scanner state; index 0 of the frame array is frame A.
    logic [ROWS-1:0]    frames [2][COLUMNS];
    logic [7:0]         pwm_phase;
    logic [3:0]         scan_col;
    logic               data_bit;
    logic               clk_level;
    logic [ROWS-1:0]    drive_rows;
    logic [BLEND_W-1:0] blend;
    logic               target_sel;

    t_levels     pending_levels[$];
    int unsigned gap_pct;
    int unsigned miss_count;
    int unsigned cycle_count;

    led_matrix_crossfade_scanner #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_element_index(i_element_index),
        .i_x_offset     (i_x_offset),
        .i_pixel_word   (i_pixel_word),
        .i_shift_amount (i_shift_amount),
        .i_last_element (i_last_element),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_row_drive    (o_row_drive),
        .o_column_data  (o_column_data),
        .o_shift_clock  (o_shift_clock)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** led_matrix_crossfade_scanner: FAILED **");
            $finish;
        end
    end

    function automatic logic [7:0] compare_point();
        if (blend <= BLEND_LOW)
            return CMP_MIN;
        if (blend > CMP_MAX)
            return CMP_MAX;
        return blend;
    endfunction

    function automatic void clear_scanner();
        for (int c = 0; c < COLUMNS; c++) begin
            frames[0][c] = '0;
            frames[1][c] = '0;
        end
        pwm_phase  = '0;
        scan_col   = '0;
        data_bit   = 1'b0;
        clk_level  = 1'b0;
        drive_rows = '0;
        blend      = BLEND_FULL;
        target_sel = 1'b0;
    endfunction

    function automatic void apply_reg_write(t_cfg_reg idx, logic [CFG_DAT_W-1:0] value);
        case (idx)
            REG_BLEND:  blend = value;
            REG_TARGET: target_sel = value[0];
            default: ;
        endcase
    endfunction

    // Applies one accepted beat and returns the output levels it leaves behind.
    function automatic t_levels scan_step(t_kind kind, logic [ELEM_W-1:0] elem,
                                          logic signed [ELEM_W-1:0] offset,
                                          logic [WORD_W-1:0] word,
                                          logic [SHIFT_W-1:0] shamt);
        logic [7:0]           pos;
        logic [SHIFTED_W-1:0] shifted;
        t_levels              lv;
        case (kind)
            KIND_TICK: begin
                pwm_phase = pwm_phase + 8'd1;
                if (pwm_phase == 8'd0) begin
                    drive_rows = (blend != BLEND_NONE) ? frames[0][scan_col] : '0;
                    clk_level  = 1'b1;
                end else if (pwm_phase == compare_point()) begin
                    drive_rows = (blend != BLEND_FULL) ? frames[1][scan_col] : '0;
                    clk_level  = 1'b0;
                    if (scan_col >= COLUMNS - 1) begin
                        data_bit = 1'b0;
                        scan_col = '0;
                    end else begin
                        if (scan_col == 0)
                            data_bit = 1'b1;
                        scan_col = scan_col + 4'd1;
                    end
                end
            end
            KIND_WRITE: begin
                pos     = elem + $unsigned(offset);
                shifted = SHIFTED_W'(word) << shamt;
                if (pos <= COLUMNS - 1)
                    frames[target_sel][pos] = shifted[ROWS-1:0];
            end
            KIND_CLEAR_COL: begin
                if (elem < COLUMNS)
                    frames[target_sel][elem] = '0;
            end
            default: begin
                for (int c = 0; c < COLUMNS; c++)
                    frames[target_sel][c] = '0;
            end
        endcase
        lv.rows      = drive_rows;
        lv.data      = data_bit;
        lv.shift_clk = clk_level;
        return lv;
    endfunction

    task automatic log_miss(string what, int unsigned want, int unsigned got);
        miss_count++;
        if (miss_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_levels want;
        if (i_rst_n && o_result_valid) begin
            if (pending_levels.size() == 0) begin
                log_miss("unexpected result beat, row_drive", 0, o_row_drive);
            end else begin
                want = pending_levels.pop_front();
                if (o_row_drive !== want.rows)
                    log_miss("row_drive", want.rows, o_row_drive);
                if (o_column_data !== want.data)
                    log_miss("column_data", want.data, o_column_data);
                if (o_shift_clock !== want.shift_clk)
                    log_miss("shift_clock", want.shift_clk, o_shift_clock);
            end
        end
    end

    // Called at a rising edge; returns at the edge that accepted the beat.
    task automatic send_item(t_kind kind, logic [ELEM_W-1:0] elem,
                             logic signed [ELEM_W-1:0] offset, logic [WORD_W-1:0] word,
                             logic [SHIFT_W-1:0] shamt, logic last);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_kind          <= kind;
        i_element_index <= elem;
        i_x_offset      <= offset;
        i_pixel_word    <= word;
        i_shift_amount  <= shamt;
        i_last_element  <= last;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_levels.push_back(scan_step(kind, elem, offset, word, shamt));
    endtask

    // Registers change only with the pipeline drained.
    task automatic write_reg(t_cfg_reg idx, logic [CFG_DAT_W-1:0] value);
        start <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        apply_reg_write(idx, value);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 8'($urandom), 8'($urandom), 16'($urandom),
                  4'($urandom), 1'($urandom));
    endtask

    task automatic fill_frame();
        for (int c = 0; c < COLUMNS; c++)
            send_item(KIND_WRITE, 8'(c), 8'sd0, 16'($urandom), 4'($urandom_range(3)),
                      c == COLUMNS - 1);
    endtask

    // Position wrap, dropped positions, truncation of the shifted word and the
    // clears that fall outside the matrix.
    task automatic test_store_edges();
        write_reg(REG_TARGET, 8'd0);
        send_item(KIND_WRITE, 8'd0, 8'sd0, 16'hFFFF, 4'd0, 1'b0);
        send_item(KIND_WRITE, 8'd11, 8'sd0, 16'h0001, 4'd15, 1'b1);
        send_item(KIND_WRITE, 8'd10, 8'sd0, 16'h0001, 4'd9, 1'b0);
        send_item(KIND_WRITE, 8'd12, 8'sd0, 16'h03FF, 4'd0, 1'b0);
        send_item(KIND_WRITE, 8'd255, 8'sd1, 16'h02AA, 4'd0, 1'b0);
        send_item(KIND_WRITE, 8'd5, -8'sd128, 16'h0155, 4'd0, 1'b1);
        send_item(KIND_WRITE, 8'd130, 8'sd127, 16'h8001, 4'd1, 1'b0);
        send_item(KIND_WRITE, 8'd0, -8'sd1, 16'h00F0, 4'd0, 1'b0);
        send_item(KIND_WRITE, 8'd3, 8'sd127, 16'h000F, 4'd2, 1'b1);
        send_item(KIND_WRITE, 8'd200, 8'sd60, 16'h7FFF, 4'd4, 1'b0);
        send_item(KIND_CLEAR_COL, 8'd12, 8'sd0, 16'h0000, 4'd0, 1'b0);
        send_item(KIND_CLEAR_COL, 8'd255, 8'sd0, 16'h0000, 4'd0, 1'b0);
        send_item(KIND_CLEAR_COL, 8'd0, 8'sd0, 16'h0000, 4'd0, 1'b0);
        send_item(KIND_CLEAR_COL, 8'd11, 8'sd0, 16'h0000, 4'd0, 1'b0);
        send_item(KIND_CLEAR_ALL, 8'hFF, -8'sd1, 16'hFFFF, 4'd15, 1'b1);
        write_reg(REG_TARGET, 8'd1);
        send_item(KIND_WRITE, 8'd6, -8'sd6, 16'h0123, 4'd3, 1'b0);
        send_item(KIND_WRITE, 8'd0, 8'sd11, 16'hC35A, 4'd5, 1'b1);
        send_item(KIND_CLEAR_ALL, 8'd0, 8'sd0, 16'h0000, 4'd0, 1'b0);
    endtask

    // A run of ticks at each blend extreme and at mid-scale, with both stores
    // filled; over the levels the counter crosses wrap and compare match several
    // times, so blanking and the column steps are exercised.
    task automatic test_blend_extremes();
        logic [BLEND_W-1:0] levels [7];
        levels = '{BLEND_FULL, BLEND_NONE, BLEND_LOW, CMP_MAX + 8'd1, CMP_MIN, CMP_MAX,
                   8'h80};
        foreach (levels[i]) begin
            write_reg(REG_BLEND, levels[i]);
            write_reg(REG_TARGET, 8'd0);
            fill_frame();
            write_reg(REG_TARGET, 8'd1);
            fill_frame();
            repeat (SLOT_TICKS) send_tick();
        end
    endtask

    task automatic random_item();
        int unsigned        pick;
        logic [ELEM_W-1:0]  elem;
        logic signed [ELEM_W-1:0] offset;
        pick   = $urandom_range(99);
        elem   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(COLUMNS + 3));
        offset = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(4) - 2);
        if (pick < 70)
            send_tick();
        else if (pick < 90)
            send_item(KIND_WRITE, elem, offset, 16'($urandom), 4'($urandom),
                      1'($urandom));
        else if (pick < 96)
            send_item(KIND_CLEAR_COL, elem, offset, 16'($urandom), 4'($urandom),
                      1'($urandom));
        else
            send_item(KIND_CLEAR_ALL, elem, offset, 16'($urandom), 4'($urandom),
                      1'($urandom));
    endtask

    task automatic test_random_mix(int unsigned sender_gap);
        logic [BLEND_W-1:0] level;
        gap_pct = sender_gap;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % RECONFIG_EVERY == 0) begin
                case ($urandom_range(5))
                    0: level = BLEND_NONE;
                    1: level = BLEND_FULL;
                    2: level = BLEND_LOW;
                    3: level = CMP_MAX + 8'd1;
                    default: level = 8'($urandom);
                endcase
                write_reg(REG_BLEND, level);
                write_reg(REG_TARGET, 8'($urandom));
            end
            random_item();
        end
    endtask

    initial begin
        clear_scanner();
        gap_pct     = 10;
        miss_count  = 0;
        cycle_count = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_store_edges();
        test_blend_extremes();
        test_random_mix(10);
        test_random_mix(82);
        test_random_mix(0);

        start <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (miss_count == 0)
            $display("** led_matrix_crossfade_scanner: PASSED **");
        else
            $display("** led_matrix_crossfade_scanner: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/lmcs_pkg.sv
rtl/core/lmcs_frame_store.sv
rtl/core/lmcs_pwm_scan.sv
rtl/core/led_matrix_crossfade_scanner.sv
dv/led_matrix_crossfade_scanner_tb.sv
